@@ hdl/sht_pkg.sv @@
// Shared types and constants of the sorted hash keyed table.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps
package sht_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W    = 2;
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the request and run the compares
    logic apply;    // update the table and load the result
  } sht_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;     // result register holds a fresh result
  } sht_stat_t;

endpackage

@@ hdl/sht_if.sv @@
// Request and response channel interfaces of the sorted hash keyed table.
// Depends on sht_pkg for field widths.
`timescale 1ns / 1ps
interface sht_req_if;
  logic                           valid;
  logic                           ready;
  logic [sht_pkg::OP_W-1:0]       op;
  logic [sht_pkg::FIELD_W-1:0]    key_hash;
  logic [sht_pkg::FIELD_W-1:0]    key;
  logic [sht_pkg::FIELD_W-1:0]    new_value;

  modport source (output valid, op, key_hash, key, new_value, input ready);
  modport sink   (input valid, op, key_hash, key, new_value, output ready);
endinterface

interface sht_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [sht_pkg::FIELD_W-1:0]    old_key;
  logic [sht_pkg::FIELD_W-1:0]    old_value;
  logic                           status;
  logic [sht_pkg::COUNT_W-1:0]    count_after;

  modport source (output valid, found, old_key, old_value, status, count_after,
                  input ready);
  modport sink   (input valid, found, old_key, old_value, status, count_after,
                  output ready);
endinterface

@@ hdl/sorted_hash_keyed_table_core.sv @@
// Top level of the sorted hash keyed table: a fixed-capacity map kept in
// ascending hash order. Depends on sht_pkg, sht_if, sht_ctrl and sht_cells.
//
//   Channel | Direction | Carries
//   --------+-----------+-----------------------------------------------
//   req     | in        | op, key_hash, key, new_value
//   rsp     | out       | found, old_key, old_value, status, count_after
//
// A request passes through these steps in order: capture it while every
// cell compares its hash, then shift or overwrite the cells and load the
// result register, then present the result until it is taken. The per-cell
// compare and the shift of the whole row at once make the time per request
// independent of the fill level.
// Reset clears the entry count and the controller; stored entries need none.
// A stalled response holds the block, and no new request is taken until the
// pending response has been delivered.
`timescale 1ns / 1ps
module sorted_hash_keyed_table_core #(
  parameter int CAPACITY    = sht_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH   = sht_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = sht_pkg::VALUE_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  sht_req_if.sink  req,
  sht_rsp_if.source rsp
);

  sht_pkg::sht_cmd_t  cmd;
  sht_pkg::sht_stat_t stat;

  // The controller sequences capture, update and response; it owns both
  // handshakes.
  sht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the sorted entries, the count and the result.
  sht_cells #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cells (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (req.op),
    .in_hash     (req.key_hash),
    .in_key      (req.key),
    .in_value    (req.new_value),
    .found       (rsp.found),
    .old_key     (rsp.old_key),
    .old_value   (rsp.old_value),
    .status      (rsp.status),
    .count_after (rsp.count_after)
  );

endmodule

@@ hdl/sht_ctrl.sv @@
// Controller state machine of the sorted hash keyed table.
// Depends on sht_pkg for the command and status structs.
`timescale 1ns / 1ps
module sht_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output sht_pkg::sht_cmd_t  cmd,
  input  sht_pkg::sht_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.apply   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.apply  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        rsp_valid = stat.done;
        if (stat.done && rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/sht_cells.sv @@
// Datapath of the sorted hash keyed table: a sorted row of entry cells with
// per-cell compare and shift, the entry count and the result register.
// Depends on sht_pkg for widths, op codes and the command and status structs.
`timescale 1ns / 1ps
module sht_cells #(
  parameter int CAPACITY    = sht_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH   = sht_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = sht_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sht_pkg::sht_cmd_t             cmd,
  output sht_pkg::sht_stat_t            stat,
  input  logic [sht_pkg::OP_W-1:0]      in_op,
  input  logic [sht_pkg::FIELD_W-1:0]   in_hash,
  input  logic [sht_pkg::FIELD_W-1:0]   in_key,
  input  logic [sht_pkg::FIELD_W-1:0]   in_value,
  output logic                          found,
  output logic [sht_pkg::FIELD_W-1:0]   old_key,
  output logic [sht_pkg::FIELD_W-1:0]   old_value,
  output logic                          status,
  output logic [sht_pkg::COUNT_W-1:0]   count_after
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [sht_pkg::FIELD_W-1:0] hashes [CAPACITY];
  logic [KEY_WIDTH-1:0]        keys   [CAPACITY];
  logic [VALUE_WIDTH-1:0]      vals   [CAPACITY];
  logic [CW-1:0]               count;

  logic [sht_pkg::OP_W-1:0]    op_q;
  logic [sht_pkg::FIELD_W-1:0] hash_q;
  logic [KEY_WIDTH-1:0]        key_q;
  logic [VALUE_WIDTH-1:0]      value_q;
  logic [CAPACITY-1:0]         lt_q;
  logic [CAPACITY-1:0]         eq_q;

  logic [KEY_WIDTH-1:0]        key_ext;
  logic [VALUE_WIDTH-1:0]      value_ext;
  logic [KEY_WIDTH-1:0]        hit_key;
  logic [VALUE_WIDTH-1:0]      hit_value;
  logic [sht_pkg::FIELD_W-1:0] hit_key32;
  logic [sht_pkg::FIELD_W-1:0] hit_value32;
  logic                        hit;
  logic                        full;
  logic                        do_over;
  logic                        do_ins;
  logic                        do_rm;

  // Resize the 32-bit request words to the stored widths and back.
  always_comb begin
    for (int j = 0; j < KEY_WIDTH; j++) begin
      key_ext[j] = (j < sht_pkg::FIELD_W) ? in_key[j % sht_pkg::FIELD_W] : 1'b0;
    end
    for (int j = 0; j < VALUE_WIDTH; j++) begin
      value_ext[j] = (j < sht_pkg::FIELD_W) ? in_value[j % sht_pkg::FIELD_W] : 1'b0;
    end
    for (int j = 0; j < sht_pkg::FIELD_W; j++) begin
      hit_key32[j]   = (j < KEY_WIDTH) ? hit_key[j % KEY_WIDTH] : 1'b0;
      hit_value32[j] = (j < VALUE_WIDTH) ? hit_value[j % VALUE_WIDTH] : 1'b0;
    end
  end

  // Hashes are unique in the table, so at most one cell matches.
  always_comb begin
    hit_key   = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_key   = hit_key | (keys[i] & {KEY_WIDTH{eq_q[i]}});
      hit_value = hit_value | (vals[i] & {VALUE_WIDTH{eq_q[i]}});
    end
  end

  assign hit     = |eq_q;
  assign full    = (count == CW'(CAPACITY));
  assign do_over = cmd.apply && (op_q == sht_pkg::OP_PUT) && hit;
  assign do_ins  = cmd.apply && (op_q == sht_pkg::OP_PUT) && !hit && !full;
  assign do_rm   = cmd.apply && (op_q == sht_pkg::OP_REMOVE) && hit;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= in_op;
      hash_q  <= in_hash;
      key_q   <= key_ext;
      value_q <= value_ext;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic live;
    assign live = (CW'(g) < count);

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        lt_q[g] <= live && (hashes[g] < in_hash);
        eq_q[g] <= live && (hashes[g] == in_hash);
      end
    end

    // Every cell at or above the insert point moves up one place; the
    // cell at the insert point takes the new entry.
    always_ff @(posedge clk) begin
      if (do_over && eq_q[g]) begin
        vals[g] <= value_q;
      end else if (do_ins && !lt_q[g]) begin
        if (g > 0 && !lt_q[(g > 0) ? g - 1 : 0]) begin
          hashes[g] <= hashes[(g > 0) ? g - 1 : 0];
          keys[g]   <= keys[(g > 0) ? g - 1 : 0];
          vals[g]   <= vals[(g > 0) ? g - 1 : 0];
        end else begin
          hashes[g] <= hash_q;
          keys[g]   <= key_q;
          vals[g]   <= value_q;
        end
      end else if (do_rm && !lt_q[g] && g < CAPACITY - 1) begin
        hashes[g] <= hashes[(g < CAPACITY - 1) ? g + 1 : g];
        keys[g]   <= keys[(g < CAPACITY - 1) ? g + 1 : g];
        vals[g]   <= vals[(g < CAPACITY - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      stat.done <= 1'b0;
    end else begin
      if (do_ins) begin
        count <= count + CW'(1);
      end else if (do_rm) begin
        count <= count - CW'(1);
      end
      if (cmd.apply) begin
        stat.done <= 1'b1;
      end else if (cmd.capture) begin
        stat.done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      found     <= hit && (op_q == sht_pkg::OP_PUT || op_q == sht_pkg::OP_GET ||
                           op_q == sht_pkg::OP_REMOVE);
      old_key   <= (op_q == sht_pkg::OP_REMOVE && hit) ? hit_key32 : '0;
      old_value <= (hit && (op_q == sht_pkg::OP_PUT || op_q == sht_pkg::OP_GET ||
                            op_q == sht_pkg::OP_REMOVE)) ? hit_value32 : '0;
      status    <= (op_q == sht_pkg::OP_PUT && !hit && full) ?
                   sht_pkg::STATUS_FULL : sht_pkg::STATUS_OK;
      if (do_ins) begin
        count_after <= sht_pkg::COUNT_W'(count + CW'(1));
      end else if (do_rm) begin
        count_after <= sht_pkg::COUNT_W'(count - CW'(1));
      end else begin
        count_after <= sht_pkg::COUNT_W'(count);
      end
    end
  end

endmodule

@@ verif/sorted_hash_keyed_table_core_tb.sv @@
// Self-checking testbench of the sorted hash keyed table core: put, get and remove
// requests against a predictor of the sorted map. Depends on sht_pkg, sht_if and the RTL.
`timescale 1ns / 1ps
module sorted_hash_keyed_table_core_tb;

  localparam int CAP = sht_pkg::CAPACITY_DEF;

  // The op code that the block treats as no operation.
  localparam logic [sht_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [sht_pkg::OP_W-1:0]    op;
    logic [sht_pkg::FIELD_W-1:0] key_hash;
    logic [sht_pkg::FIELD_W-1:0] key;
    logic [sht_pkg::FIELD_W-1:0] new_value;
  } table_req_t;

  typedef struct packed {
    logic                        found;
    logic [sht_pkg::FIELD_W-1:0] old_key;
    logic [sht_pkg::FIELD_W-1:0] old_value;
    logic                        status;
    logic [sht_pkg::COUNT_W-1:0] count_after;
  } table_rsp_t;

  logic clk;
  logic rst;

  sht_req_if req_ch();
  sht_rsp_if rsp_ch();

  sorted_hash_keyed_table_core u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  // Requests wait here until the driver offers them; the predicted responses
  // of accepted requests wait in the second queue for the monitor.
  table_req_t pending_reqs[$];
  table_rsp_t expected_rsps[$];

  // Mirror of the table contents, kept in ascending hash order.
  logic [sht_pkg::FIELD_W-1:0] mirror_hash[CAP];
  logic [sht_pkg::FIELD_W-1:0] mirror_key[CAP];
  logic [sht_pkg::FIELD_W-1:0] mirror_value[CAP];
  int unsigned        mirror_count;

  // Hashes that are known to be in the table, used to aim requests at hits.
  logic [sht_pkg::FIELD_W-1:0] live_hashes[$];

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned accepted_count;
  int unsigned response_count;
  int unsigned hit_count;
  int unsigned full_count;
  int unsigned peak_count;
  bit          stim_done;
  bit          hold_off_req;   // receiver holds off a long stretch when set
  bit          no_idle;        // both sides run without gaps when set
  bit          drv_pause;      // sender offers nothing while set
  bit          req_fired;      // the offered request was taken at the last rising edge

  // Applies one request to the mirror and returns the response it must cause.
  function automatic table_rsp_t apply_table_op(table_req_t r);
    table_rsp_t res;
    int unsigned lo, hi, mid, pos;
    bit hit;
    res = '0;
    lo = 0;
    hi = mirror_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (mirror_hash[mid] < r.key_hash) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    hit = (pos < mirror_count) && (mirror_hash[pos] == r.key_hash);
    case (r.op)
      sht_pkg::OP_PUT: begin
        if (hit) begin
          res.found = 1'b1;
          res.old_value = mirror_value[pos];
          mirror_value[pos] = r.new_value;
        end else if (mirror_count >= CAP) begin
          res.status = sht_pkg::STATUS_FULL;
        end else begin
          for (int i = mirror_count; i > pos; i--) begin
            mirror_hash[i] = mirror_hash[i-1];
            mirror_key[i] = mirror_key[i-1];
            mirror_value[i] = mirror_value[i-1];
          end
          mirror_hash[pos] = r.key_hash;
          mirror_key[pos] = r.key;
          mirror_value[pos] = r.new_value;
          mirror_count++;
        end
      end
      sht_pkg::OP_GET: begin
        if (hit) begin
          res.found = 1'b1;
          res.old_value = mirror_value[pos];
        end
      end
      sht_pkg::OP_REMOVE: begin
        if (hit) begin
          res.found = 1'b1;
          res.old_key = mirror_key[pos];
          res.old_value = mirror_value[pos];
          for (int i = pos; i + 1 < mirror_count; i++) begin
            mirror_hash[i] = mirror_hash[i+1];
            mirror_key[i] = mirror_key[i+1];
            mirror_value[i] = mirror_value[i+1];
          end
          mirror_count--;
        end
      end
      default: ;  // the spare op code leaves the table alone
    endcase
    res.count_after = mirror_count[sht_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic table_req_t make_req(logic [sht_pkg::OP_W-1:0] op,
                                          logic [sht_pkg::FIELD_W-1:0] h,
                                          logic [sht_pkg::FIELD_W-1:0] k,
                                          logic [sht_pkg::FIELD_W-1:0] v);
    table_req_t r;
    r.op = op;
    r.key_hash = h;
    r.key = k;
    r.new_value = v;
    return r;
  endfunction

  // Picks a hash: often one that should be present, else a clustered, near-maximum or fresh one.
  function automatic logic [sht_pkg::FIELD_W-1:0] pick_hash();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45 && live_hashes.size() > 0)
      return live_hashes[$urandom_range(0, live_hashes.size() - 1)];
    if (sel < 70)
      return $urandom_range(0, 95);  // dense cluster gives ties and neighbors
    if (sel < 75)
      return {sht_pkg::FIELD_W{1'b1}} - $urandom_range(0, 3);
    return $urandom;
  endfunction

  // Tracks likely-live hashes at generation time; stale entries only lower hit rates.
  task automatic push_req(table_req_t r);
    pending_reqs.push_back(r);
    if (r.op == sht_pkg::OP_PUT) begin
      live_hashes.push_back(r.key_hash);
      if (live_hashes.size() > 200) void'(live_hashes.pop_front());
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and timeout. The limit leaves room for the slowest run, with
  // random gaps on both sides and the long hold-off stretch.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_rsps.size());
      $display("sorted_hash_keyed_table_core_tb: FAIL");
      $finish;
    end
  end

  // Driver: offers the oldest pending request, changing inputs at the falling
  // edge. An offered request stays on the lines until it has been taken.
  always @(negedge clk) begin
    if (rst) begin
      req_fired = 1'b0;
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_fired) begin
      // Request not taken yet: hold it steady.
    end else begin
      req_fired = 1'b0;
      if (pending_reqs.size() > 0 && !drv_pause &&
          (no_idle || $urandom_range(0, 99) >= 37)) begin
        table_req_t r;
        r = pending_reqs[0];
        req_ch.valid <= 1'b1;
        req_ch.op <= r.op;
        req_ch.key_hash <= r.key_hash;
        req_ch.key <= r.key;
        req_ch.new_value <= r.new_value;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Acceptance: a request moves at the rising edge where valid and ready are
  // both high; its predicted response is queued at that same edge.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      table_req_t r;
      table_rsp_t e;
      r = pending_reqs.pop_front();
      e = apply_table_op(r);
      expected_rsps.push_back(e);
      req_fired = 1'b1;
      accepted_count++;
      if (e.found) hit_count++;
      if (e.status == sht_pkg::STATUS_FULL) full_count++;
      if (mirror_count > peak_count) peak_count = mirror_count;
    end
  end

  // Receiver ready, changed at the falling edge like every other input.
  always @(negedge clk) begin
    if (rst || hold_off_req) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 37);
  end

  // Monitor: compares each delivered response with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      table_rsp_t got, e;
      got.found = rsp_ch.found;
      got.old_key = rsp_ch.old_key;
      got.old_value = rsp_ch.old_value;
      got.status = rsp_ch.status;
      got.count_after = rsp_ch.count_after;
      response_count++;
      if (expected_rsps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected response %p at cycle %0d", got, cycle_count);
      end else begin
        e = expected_rsps.pop_front();
        if (got !== e) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("response %0d mismatch: expected %p, got %p",
                     response_count, e, got);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int unsigned sel;
    logic [sht_pkg::FIELD_W-1:0] h;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = '0;
    req_ch.key_hash = '0;
    req_ch.key = '0;
    req_ch.new_value = '0;
    rsp_ch.ready = 1'b0;
    cycle_count = 0;
    mismatch_count = 0;
    accepted_count = 0;
    response_count = 0;
    hit_count = 0;
    full_count = 0;
    peak_count = 0;
    mirror_count = 0;
    stim_done = 1'b0;
    hold_off_req = 1'b0;
    no_idle = 1'b0;
    drv_pause = 1'b0;
    req_fired = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: misses on an empty table, the spare op code, extreme
    // fields, overwrite on a hit, removes at both ends and in the middle.
    push_req(make_req(sht_pkg::OP_GET, 32'h0, 32'h0, 32'h0));
    push_req(make_req(sht_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0));
    push_req(make_req(OP_SPARE, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_req(make_req(sht_pkg::OP_PUT, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555));
    push_req(make_req(sht_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    push_req(make_req(sht_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0, 32'h0));
    push_req(make_req(sht_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA));
    push_req(make_req(sht_pkg::OP_GET, 32'h0, 32'h0, 32'h0));
    push_req(make_req(sht_pkg::OP_GET, 32'hFFFF_FFFF, 32'h1, 32'h1));
    push_req(make_req(sht_pkg::OP_PUT, 32'h8000_0000, 32'h1111_1111, 32'hDEAD_BEEF));  // alias
    push_req(make_req(sht_pkg::OP_GET, 32'h8000_0001, 32'h0, 32'h0));
    push_req(make_req(OP_SPARE, 32'h8000_0000, 32'h0, 32'h0));
    push_req(make_req(sht_pkg::OP_REMOVE, 32'h8000_0000, 32'h0, 32'h0));
    push_req(make_req(sht_pkg::OP_REMOVE, 32'h0, 32'h0, 32'h0));
    push_req(make_req(sht_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0));
    push_req(make_req(sht_pkg::OP_REMOVE, 32'h7FFF_FFFF, 32'h0, 32'h0));
    push_req(make_req(sht_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0, 32'h0));
    wait_drained();

    // Fill the table to capacity in descending order, so every insert lands
    // at the front, then probe the full cases: overwrite on a hit, refusal
    // on a miss. The receiver holds off meanwhile, so the block backs up.
    hold_off_req = 1'b1;
    for (int i = CAP; i > 0; i--)
      push_req(make_req(sht_pkg::OP_PUT, i * 16, $urandom, $urandom));
    push_req(make_req(sht_pkg::OP_PUT, 32'd16, $urandom, $urandom));
    push_req(make_req(sht_pkg::OP_PUT, 32'd15, $urandom, $urandom));
    push_req(make_req(sht_pkg::OP_PUT, 32'hFFFF_FFFF, $urandom, $urandom));
    push_req(make_req(sht_pkg::OP_PUT, 32'd0, $urandom, $urandom));
    repeat (300) @(posedge clk);
    hold_off_req = 1'b0;
    wait_drained();

    // Random part. Phases alternate between filling and draining so that
    // the count sweeps the whole range and the full table is reached again.
    for (int ph = 0; ph < 12; ph++) begin
      no_idle = (ph == 3);
      for (n = 0; n < 110; n++) begin
        sel = $urandom_range(0, 99);
        h = pick_hash();
        if (sel < 6)
          push_req(make_req(OP_SPARE, $urandom, $urandom, $urandom));
        else if (sel < ((ph % 2 == 0) ? 60 : 25))
          push_req(make_req(sht_pkg::OP_PUT, h, $urandom, $urandom));
        else if (sel < 60)
          push_req(make_req(sht_pkg::OP_REMOVE, h, $urandom, $urandom));
        else
          push_req(make_req(sht_pkg::OP_GET, h, $urandom, $urandom));
      end
      if (ph == 5) begin
        // The sender stops until every response has come back.
        drv_pause = 1'b1;
        while (expected_rsps.size() > 0) @(posedge clk);
        drv_pause = 1'b0;
      end
      wait_drained();
    end
    no_idle = 1'b0;
    stim_done = 1'b1;

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d requests: %0d hits, %0d refusals on a full table, peak fill %0d",
             accepted_count, hit_count, full_count, peak_count);
    $display("%0d responses checked, %0d mismatches", response_count, mismatch_count);
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("sorted_hash_keyed_table_core_tb: PASS");
    end else begin
      $display("sorted_hash_keyed_table_core_tb: FAIL");
    end
    $finish;
  end

endmodule
